FILE: hw/rtl/apbc_pkg.sv
// Shared types, constants and helpers for the armed PD balance controller.
package apbc_pkg;

    // Field and register widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int ANGLE_W    = 17;
    localparam int RATE_W     = 20;
    localparam int IVL_W      = 20;
    localparam int TIME_W     = 32;
    localparam int DRIVE_W    = 25;
    localparam int MODE_W     = 2;
    localparam int GAIN_W     = 24;
    localparam int WIN_W      = 16;
    localparam int LIMIT_W    = 24;
    localparam int FILT_W     = 28;

    // Register indexes on the config port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN    = 3'd0,
        REG_DERIV_GAIN   = 3'd1,
        REG_TARGET_ANGLE = 3'd2,
        REG_ARM_WINDOW   = 3'd3,
        REG_DISARM_THR   = 3'd4,
        REG_HOLD_TIME    = 3'd5,
        REG_DRIVE_LIMIT  = 3'd6,
        REG_SLEW_RATE    = 3'd7
    } cfg_reg_t;

    // Register reset values
    localparam logic [GAIN_W-1:0]  RST_PROP_GAIN    = 24'd65536;
    localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN   = 24'd3277;
    localparam logic [ANGLE_W-1:0] RST_TARGET_ANGLE = 17'd23040;
    localparam logic [WIN_W-1:0]   RST_ARM_WINDOW   = 16'd2560;
    localparam logic [WIN_W-1:0]   RST_DISARM_THR   = 16'd4352;
    localparam logic [WIN_W-1:0]   RST_HOLD_TIME    = 16'd200;
    localparam logic [LIMIT_W-1:0] RST_DRIVE_LIMIT  = 24'd5120000;
    localparam logic [LIMIT_W-1:0] RST_SLEW_RATE    = 24'd1024000;

    // Loop constants
    localparam logic [RATE_W-1:0]  RATE_ARM_LIMIT    = 20'd15360;
    localparam logic [IVL_W-1:0]   DEFAULT_PERIOD_US = 20'd10000;
    localparam logic [WIN_W-1:0]   MIN_HOLD_MS       = 16'd50;
    localparam logic [LIMIT_W-1:0] MIN_LIMIT         = 24'd256;
    localparam logic [WIN_W:0]     DISARM_MARGIN     = 17'd256;

    localparam logic signed [8:0]        FILT_KEEP  = 9'sd218;
    localparam logic signed [14:0]       FILT_NEW   = 15'sd9728;   // 38 * 256
    localparam logic signed [FILT_W-1:0] FILT_MAX   = 28'sh7FFFFFF;
    localparam logic signed [FILT_W-1:0] FILT_MIN   = 28'h8000000;
    localparam logic signed [FILT_W-1:0] RATE_DEAD  = 28'sd65536;
    localparam logic signed [17:0]       ERR_DEAD   = 18'sd128;
    localparam logic signed [29:0]       DRIVE_DEAD = 30'sd38;
    localparam logic signed [8:0]        BLEED_NUM  = 9'sd225;

    // Slew step = floor(slew*dt / 10^6) = floor((slew*dt >> 6) / 15625)
    localparam logic [13:0] SLEW_DIV_ODD = 14'd15625;
    localparam logic [24:0] SLEW_RECIP   = 25'd17592186;            // floor(2^38/15625)

    // Mode codes on the result channel
    localparam logic [MODE_W-1:0] MODE_CODE_DISABLED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CODE_ARMING   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CODE_ENABLED  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CODE_RESERVED = 2'd3;

    typedef enum logic [2:0] {
        LOOP_DISABLED = 3'b001,
        LOOP_ARMING   = 3'b010,
        LOOP_ENABLED  = 3'b100
    } loop_mode_t;

    // Operand select of the shared multiplier
    typedef enum logic [1:0] {
        MUL_SLEW  = 2'd0,
        MUL_RECIP = 2'd1,
        MUL_PROP  = 2'd2,
        MUL_DERIV = 2'd3
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     eval;
        mul_sel_t mul_sel;
        logic     div_load;
        logic     div_split;
        logic     div_fix;
        logic     acc_prop;
        logic     law;
        logic     shape;
        logic     slew;
        logic     emit;
    } cmd_t;

    typedef struct packed {
        logic run_law;
        logic out_free;
    } status_t;

    // Effective register values, minimums already applied
    typedef struct packed {
        logic signed [GAIN_W-1:0]  prop_gain;
        logic signed [GAIN_W-1:0]  deriv_gain;
        logic signed [ANGLE_W-1:0] target_angle;
        logic [WIN_W-1:0]          arm_window;
        logic [WIN_W:0]            disarm_thr;
        logic [WIN_W-1:0]          hold_ms;
        logic [LIMIT_W-1:0]        drive_limit;
        logic [LIMIT_W-1:0]        slew_rate;
    } cfg_t;

    function automatic logic [MODE_W-1:0] mode_code(loop_mode_t m);
        logic [MODE_W-1:0] c;
        case (m)
            LOOP_ARMING:  c = MODE_CODE_ARMING;
            LOOP_ENABLED: c = MODE_CODE_ENABLED;
            default:      c = MODE_CODE_DISABLED;
        endcase
        return c;
    endfunction

endpackage

FILE: hw/rtl/apbc_if.sv
// Valid/ready channel interfaces for sensor beats and drive result beats.
interface apbc_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 sample_valid;
    logic signed [apbc_pkg::ANGLE_W-1:0]  roll_angle;
    logic signed [apbc_pkg::RATE_W-1:0]   roll_rate;
    logic [apbc_pkg::IVL_W-1:0]           interval_us;
    logic [apbc_pkg::TIME_W-1:0]          time_ms;

    modport source (output valid, sample_valid, roll_angle, roll_rate, interval_us, time_ms,
                    input ready);
    modport sink   (input valid, sample_valid, roll_angle, roll_rate, interval_us, time_ms,
                    output ready);
endinterface

interface apbc_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [apbc_pkg::DRIVE_W-1:0]  drive;
    logic [apbc_pkg::MODE_W-1:0]          mode;
    logic [apbc_pkg::IVL_W-1:0]           interval_out_us;

    modport source (output valid, drive, mode, interval_out_us, input ready);
    modport sink   (input valid, drive, mode, interval_out_us, output ready);
endinterface

FILE: hw/rtl/apbc_cfg.sv
// Configuration register file with minimum enforcement on the derived values.
module apbc_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [apbc_pkg::CFG_IDX_W-1:0]      index,
    input  logic [apbc_pkg::CFG_DATA_W-1:0]     data,
    output apbc_pkg::cfg_t                      cfg
);

    logic [apbc_pkg::GAIN_W-1:0]  prop_gain_reg;
    logic [apbc_pkg::GAIN_W-1:0]  deriv_gain_reg;
    logic [apbc_pkg::ANGLE_W-1:0] target_reg;
    logic [apbc_pkg::WIN_W-1:0]   window_reg;
    logic [apbc_pkg::WIN_W-1:0]   disarm_reg;
    logic [apbc_pkg::WIN_W-1:0]   hold_reg;
    logic [apbc_pkg::LIMIT_W-1:0] limit_reg;
    logic [apbc_pkg::LIMIT_W-1:0] slew_reg;
    logic [apbc_pkg::WIN_W:0]     win_plus;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg  <= apbc_pkg::RST_PROP_GAIN;
            deriv_gain_reg <= apbc_pkg::RST_DERIV_GAIN;
            target_reg     <= apbc_pkg::RST_TARGET_ANGLE;
            window_reg     <= apbc_pkg::RST_ARM_WINDOW;
            disarm_reg     <= apbc_pkg::RST_DISARM_THR;
            hold_reg       <= apbc_pkg::RST_HOLD_TIME;
            limit_reg      <= apbc_pkg::RST_DRIVE_LIMIT;
            slew_reg       <= apbc_pkg::RST_SLEW_RATE;
        end
        else if (wr_en)
        begin
            case (apbc_pkg::cfg_reg_t'(index))
                apbc_pkg::REG_PROP_GAIN:    prop_gain_reg  <= data;
                apbc_pkg::REG_DERIV_GAIN:   deriv_gain_reg <= data;
                apbc_pkg::REG_TARGET_ANGLE: target_reg     <= data[apbc_pkg::ANGLE_W-1:0];
                apbc_pkg::REG_ARM_WINDOW:   window_reg     <= data[apbc_pkg::WIN_W-1:0];
                apbc_pkg::REG_DISARM_THR:   disarm_reg     <= data[apbc_pkg::WIN_W-1:0];
                apbc_pkg::REG_HOLD_TIME:    hold_reg       <= data[apbc_pkg::WIN_W-1:0];
                apbc_pkg::REG_DRIVE_LIMIT:  limit_reg      <= data;
                apbc_pkg::REG_SLEW_RATE:    slew_reg       <= data;
                default:                    ;
            endcase
        end
    end

    // Effective values: disarm at least window + 1 deg, hold and limit floored
    assign win_plus = {1'b0, window_reg} + apbc_pkg::DISARM_MARGIN;

    always_comb
    begin
        cfg.prop_gain    = $signed(prop_gain_reg);
        cfg.deriv_gain   = $signed(deriv_gain_reg);
        cfg.target_angle = $signed(target_reg);
        cfg.arm_window   = window_reg;
        cfg.disarm_thr   = ({1'b0, disarm_reg} < win_plus) ? win_plus : {1'b0, disarm_reg};
        cfg.hold_ms      = (hold_reg < apbc_pkg::MIN_HOLD_MS) ? apbc_pkg::MIN_HOLD_MS : hold_reg;
        cfg.drive_limit  = (limit_reg < apbc_pkg::MIN_LIMIT) ? apbc_pkg::MIN_LIMIT : limit_reg;
        cfg.slew_rate    = slew_reg;
    end

endmodule

FILE: hw/rtl/apbc_ctrl.sv
// Sequencer that steps the datapath through one control period per beat.
module apbc_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  apbc_pkg::status_t    status,
    output apbc_pkg::cmd_t       cmd
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_EVAL  = 9'b000000010,
        ST_STEP  = 9'b000000100,
        ST_PTERM = 9'b000001000,
        ST_DTERM = 9'b000010000,
        ST_LAW   = 9'b000100000,
        ST_SHAPE = 9'b001000000,
        ST_SLEW  = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_EVAL;
            ST_EVAL:  state_next = status.run_law ? ST_STEP : ST_OUT;
            ST_STEP:  state_next = ST_PTERM;
            ST_PTERM: state_next = ST_DTERM;
            ST_DTERM: state_next = ST_LAW;
            ST_LAW:   state_next = ST_SHAPE;
            ST_SHAPE: state_next = ST_SLEW;
            ST_SLEW:  state_next = ST_OUT;
            ST_OUT:   if (status.out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);

    // Datapath commands
    always_comb
    begin
        cmd           = '0;
        cmd.mul_sel   = apbc_pkg::MUL_SLEW;
        cmd.load      = (state_reg == ST_IDLE) && in_valid;
        cmd.eval      = (state_reg == ST_EVAL);
        cmd.div_load  = (state_reg == ST_STEP);
        cmd.div_split = (state_reg == ST_PTERM);
        cmd.div_fix   = (state_reg == ST_DTERM) || (state_reg == ST_LAW);
        cmd.acc_prop  = (state_reg == ST_DTERM);
        cmd.law       = (state_reg == ST_LAW);
        cmd.shape     = (state_reg == ST_SHAPE);
        cmd.slew      = (state_reg == ST_SLEW);
        cmd.emit      = (state_reg == ST_OUT) && status.out_free;
        case (state_reg)
            ST_STEP:  cmd.mul_sel = apbc_pkg::MUL_RECIP;
            ST_PTERM: cmd.mul_sel = apbc_pkg::MUL_PROP;
            ST_DTERM: cmd.mul_sel = apbc_pkg::MUL_DERIV;
            default:  cmd.mul_sel = apbc_pkg::MUL_SLEW;
        endcase
    end

endmodule

FILE: hw/rtl/apbc_dp.sv
// Datapath: mode machine, rate filter, shared multiplier, PD law, shaping, result register.
module apbc_dp
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  apbc_pkg::cmd_t                         cmd,
    input  apbc_pkg::cfg_t                         cfg,
    input  logic                                   sample_valid,
    input  logic signed [apbc_pkg::ANGLE_W-1:0]    roll_angle,
    input  logic signed [apbc_pkg::RATE_W-1:0]     roll_rate,
    input  logic [apbc_pkg::IVL_W-1:0]             interval_us,
    input  logic [apbc_pkg::TIME_W-1:0]            time_ms,
    output apbc_pkg::status_t                      status,
    apbc_out_if.source                             actuator
);

    // Captured beat
    logic                                  valid_in_reg;
    logic signed [apbc_pkg::ANGLE_W-1:0]   angle_reg;
    logic signed [apbc_pkg::RATE_W-1:0]    rate_reg;
    logic [apbc_pkg::IVL_W-1:0]            interval_reg;
    logic [apbc_pkg::TIME_W-1:0]           now_reg;

    // Loop state
    apbc_pkg::loop_mode_t                  mode_reg;
    apbc_pkg::loop_mode_t                  mode_next;
    logic [apbc_pkg::TIME_W-1:0]           entry_reg;
    logic signed [apbc_pkg::DRIVE_W-1:0]   last_drive_reg;
    logic signed [apbc_pkg::FILT_W-1:0]    filt_reg;

    // Work registers
    logic signed [55:0]                    mul_reg;
    logic signed [17:0]                    err_db_reg;
    logic signed [apbc_pkg::FILT_W-1:0]    fdb_reg;
    logic [37:0]                           y_reg;
    logic [24:0]                           q_reg;
    logic [16:0]                           rem_reg;
    logic signed [53:0]                    acc_reg;
    logic signed [29:0]                    u_reg;
    logic signed [apbc_pkg::DRIVE_W-1:0]   ushape_reg;

    // Result register
    logic                                  out_valid_reg;
    logic signed [apbc_pkg::DRIVE_W-1:0]   out_drive_reg;
    logic [apbc_pkg::MODE_W-1:0]           out_mode_reg;
    logic [apbc_pkg::IVL_W-1:0]            out_ivl_reg;

    // Mode evaluation signals
    logic signed [17:0]                    err;
    logic [17:0]                           err_abs;
    logic [apbc_pkg::RATE_W-1:0]           rate_abs;
    logic                                  in_window;
    logic                                  hold_ok;
    logic                                  too_far;
    logic [apbc_pkg::TIME_W-1:0]           elapsed;
    logic                                  run_law;
    logic                                  enter_arm;
    logic                                  enable_edge;

    // Filter signals
    logic signed [37:0]                    filt_sum;
    logic signed [37:0]                    filt_shift;
    logic signed [apbc_pkg::FILT_W-1:0]    filt_new;

    // Multiplier and divide signals
    logic [apbc_pkg::IVL_W-1:0]            dt;
    logic signed [27:0]                    op_a;
    logic signed [27:0]                    op_b;
    logic signed [55:0]                    mul_full;
    logic [24:0]                           q_est;
    logic [37:0]                           rem_full;
    logic signed [53:0]                    law_diff;

    // Shaping signals
    logic signed [29:0]                    lim_s;
    logic signed [apbc_pkg::DRIVE_W-1:0]   shaped;
    logic signed [33:0]                    bleed_prod;
    logic signed [25:0]                    bleed_q;
    logic signed [26:0]                    delta;
    logic signed [26:0]                    step_s;
    logic signed [26:0]                    slewed;
    logic signed [apbc_pkg::DRIVE_W-1:0]   drive_next;

    // Beat capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            valid_in_reg <= sample_valid;
            angle_reg    <= roll_angle;
            rate_reg     <= roll_rate;
            interval_reg <= interval_us;
            now_reg      <= time_ms;
        end
    end

    // Window tests and mode transitions
    assign err      = 18'(cfg.target_angle) - 18'(angle_reg);
    assign err_abs  = err[17] ? 18'(-err) : 18'(err);
    assign rate_abs = rate_reg[apbc_pkg::RATE_W-1] ? apbc_pkg::RATE_W'(-rate_reg)
                                                   : apbc_pkg::RATE_W'(rate_reg);
    assign in_window = (err_abs <= {2'b00, cfg.arm_window})
                       && (rate_abs <= apbc_pkg::RATE_ARM_LIMIT);
    assign elapsed  = now_reg - entry_reg;
    assign hold_ok  = elapsed >= {16'b0, cfg.hold_ms};
    assign too_far  = err_abs >= {1'b0, cfg.disarm_thr};

    always_comb
    begin
        case (mode_reg)
            apbc_pkg::LOOP_ARMING:
                mode_next = !in_window ? apbc_pkg::LOOP_DISABLED
                          : (hold_ok ? apbc_pkg::LOOP_ENABLED : apbc_pkg::LOOP_ARMING);
            apbc_pkg::LOOP_ENABLED:
                mode_next = too_far ? apbc_pkg::LOOP_DISABLED : apbc_pkg::LOOP_ENABLED;
            default:
                mode_next = in_window ? apbc_pkg::LOOP_ARMING : apbc_pkg::LOOP_DISABLED;
        endcase
        if (!valid_in_reg)
            mode_next = apbc_pkg::LOOP_DISABLED;
    end

    assign run_law     = valid_in_reg && (mode_next == apbc_pkg::LOOP_ENABLED);
    assign enter_arm   = valid_in_reg && (mode_reg != apbc_pkg::LOOP_ARMING)
                         && (mode_reg != apbc_pkg::LOOP_ENABLED) && in_window;
    assign enable_edge = valid_in_reg && (mode_reg == apbc_pkg::LOOP_ARMING)
                         && (mode_next == apbc_pkg::LOOP_ENABLED);

    // Rate filter: f = floor((218*f + 38*256*rate) / 256), saturated to 28 bits
    assign filt_sum   = 38'(apbc_pkg::FILT_KEEP) * 38'(filt_reg)
                      + 38'(apbc_pkg::FILT_NEW) * 38'(rate_reg);
    assign filt_shift = filt_sum >>> 8;

    always_comb
    begin
        if (filt_shift > 38'(apbc_pkg::FILT_MAX))
            filt_new = apbc_pkg::FILT_MAX;
        else if (filt_shift < 38'(apbc_pkg::FILT_MIN))
            filt_new = apbc_pkg::FILT_MIN;
        else
            filt_new = filt_shift[apbc_pkg::FILT_W-1:0];
    end

    // Shared 28x28 multiplier
    assign dt = (interval_reg == '0) ? apbc_pkg::DEFAULT_PERIOD_US : interval_reg;

    always_comb
    begin
        case (cmd.mul_sel)
            apbc_pkg::MUL_RECIP:
            begin
                op_a = $signed({2'b00, mul_reg[43:18]});
                op_b = $signed({3'b000, apbc_pkg::SLEW_RECIP});
            end
            apbc_pkg::MUL_PROP:
            begin
                op_a = 28'(cfg.prop_gain);
                op_b = 28'(err_db_reg);
            end
            apbc_pkg::MUL_DERIV:
            begin
                op_a = 28'(cfg.deriv_gain);
                op_b = fdb_reg;
            end
            default:
            begin
                op_a = $signed({4'b0000, cfg.slew_rate});
                op_b = $signed({8'b0, dt});
            end
        endcase
    end

    assign mul_full = op_a * op_b;

    always_ff @(posedge clk)
    begin
        mul_reg <= mul_full;
    end

    // Loop state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= apbc_pkg::LOOP_DISABLED;
            entry_reg      <= '0;
            last_drive_reg <= '0;
            filt_reg       <= '0;
        end
        else if (cmd.eval)
        begin
            mode_reg <= mode_next;
            if (enter_arm)
                entry_reg <= now_reg;
            if (run_law)
                filt_reg <= filt_new;
            if (!run_law || enable_edge)
                last_drive_reg <= '0;
        end
        else if (cmd.slew)
        begin
            last_drive_reg <= drive_next;
        end
    end

    // Deadbanded error and filtered rate
    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            err_db_reg <= ((err < apbc_pkg::ERR_DEAD) && (err > -apbc_pkg::ERR_DEAD)) ? '0 : err;
            fdb_reg    <= ((filt_new < apbc_pkg::RATE_DEAD) && (filt_new > -apbc_pkg::RATE_DEAD))
                          ? '0 : filt_new;
        end
    end

    // Slew step: reciprocal estimate, then up to two remainder corrections
    assign q_est    = mul_reg[50:26];
    assign rem_full = y_reg - 38'(q_est) * 38'(apbc_pkg::SLEW_DIV_ODD);

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
            y_reg <= mul_reg[43:6];
        if (cmd.div_split)
        begin
            q_reg   <= q_est;
            rem_reg <= rem_full[16:0];
        end
        else if (cmd.div_fix && (rem_reg >= 17'(apbc_pkg::SLEW_DIV_ODD)))
        begin
            q_reg   <= q_reg + 25'd1;
            rem_reg <= rem_reg - 17'(apbc_pkg::SLEW_DIV_ODD);
        end
    end

    // PD law: u = floor((kp*e*256 - kd*f) / 2^24)
    assign law_diff = acc_reg - 54'($signed(mul_reg[51:0]));

    always_ff @(posedge clk)
    begin
        if (cmd.acc_prop)
            acc_reg <= {{4{mul_reg[41]}}, mul_reg[41:0], 8'b0};
        if (cmd.law)
            u_reg <= law_diff[53:24];
        if (cmd.shape)
            ushape_reg <= shaped;
    end

    // Drive deadband and clamp
    assign lim_s = $signed({6'b0, cfg.drive_limit});

    always_comb
    begin
        if ((u_reg <= apbc_pkg::DRIVE_DEAD) && (u_reg >= -apbc_pkg::DRIVE_DEAD))
            shaped = '0;
        else if (u_reg > lim_s)
            shaped = apbc_pkg::DRIVE_W'(lim_s);
        else if (u_reg < -lim_s)
            shaped = apbc_pkg::DRIVE_W'(-lim_s);
        else
            shaped = u_reg[apbc_pkg::DRIVE_W-1:0];
    end

    // Bleed toward zero (truncating) or slew-limited move toward u
    assign bleed_prod = 34'(last_drive_reg) * 34'(apbc_pkg::BLEED_NUM);
    assign bleed_q    = 26'(bleed_prod >>> 8)
                      + 26'((bleed_prod[33] && (bleed_prod[7:0] != 8'd0)) ? 1 : 0);
    assign delta      = 27'(ushape_reg) - 27'(last_drive_reg);
    assign step_s     = $signed({2'b00, q_reg});

    always_comb
    begin
        if (delta > step_s)
            slewed = 27'(last_drive_reg) + step_s;
        else if (delta < -step_s)
            slewed = 27'(last_drive_reg) - step_s;
        else
            slewed = 27'(ushape_reg);

        if (ushape_reg == '0)
        begin
            if ((30'(bleed_q) <= apbc_pkg::DRIVE_DEAD) && (30'(bleed_q) >= -apbc_pkg::DRIVE_DEAD))
                drive_next = '0;
            else
                drive_next = bleed_q[apbc_pkg::DRIVE_W-1:0];
        end
        else
        begin
            drive_next = slewed[apbc_pkg::DRIVE_W-1:0];
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (actuator.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_drive_reg <= last_drive_reg;
            out_mode_reg  <= apbc_pkg::mode_code(mode_reg);
            out_ivl_reg   <= valid_in_reg ? interval_reg : apbc_pkg::DEFAULT_PERIOD_US;
        end
    end

    assign actuator.valid           = out_valid_reg;
    assign actuator.drive           = out_drive_reg;
    assign actuator.mode            = out_mode_reg;
    assign actuator.interval_out_us = out_ivl_reg;

    assign status.run_law  = run_law;
    assign status.out_free = !out_valid_reg || actuator.ready;

endmodule

FILE: hw/rtl/armed_pd_balance_controller_core.sv
// Top level of the armed PD balance controller: config, sequencer and datapath.
//
//  channel    dir   beat contents
//  ---------  ----  ------------------------------------------------------------
//  sensor     in    sample_valid, roll_angle, roll_rate, interval_us, time_ms
//  actuator   out   drive, mode, interval_out_us
//  cfg_*      in    cfg_wr_en, cfg_index, cfg_data (write only)
//
//  A beat with the loop enabled steps from one accept to the next through idle,
//  mode eval with slew multiply, reciprocal multiply, P term, D term, law,
//  shaping, slew and result; otherwise through idle, eval and result. The single
//  shared 28x28 multiplier gives each multiply its own state. Reset clears the
//  loop state and the registers to their defaults. A result waiting in the output
//  register does not block the next accept; the sequencer holds in its result
//  state only while that register is still full and not taken.
module armed_pd_balance_controller_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    apbc_in_if.sink                           sensor,
    apbc_out_if.source                        actuator,
    input  logic                              cfg_wr_en,
    input  logic [apbc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [apbc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    apbc_pkg::cfg_t     cfg;
    apbc_pkg::cmd_t     cmd;
    apbc_pkg::status_t  status;
    logic               in_ready;

    apbc_cfg u_cfg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (cfg_wr_en),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    apbc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sensor.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    apbc_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg          (cfg),
        .sample_valid (sensor.sample_valid),
        .roll_angle   (sensor.roll_angle),
        .roll_rate    (sensor.roll_rate),
        .interval_us  (sensor.interval_us),
        .time_ms      (sensor.time_ms),
        .status       (status),
        .actuator     (actuator)
    );

    assign sensor.ready = in_ready;

    // An accepted beat is evaluated in the next cycle
    a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (sensor.valid && sensor.ready) |=> cmd.eval)
        else $error("accepted beat not evaluated");

    // A loaded result shows up on the output channel
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> actuator.valid)
        else $error("result not presented");

    // Drive is zero unless the loop is enabled
    a_drive_gated: assert property (@(posedge clk) disable iff (!rst_n)
        (actuator.valid && (actuator.mode != apbc_pkg::MODE_CODE_ENABLED))
            |-> (actuator.drive == '0))
        else $error("nonzero drive while not enabled");

    // The reserved mode code is never reported
    a_mode_code: assert property (@(posedge clk) disable iff (!rst_n)
        actuator.valid |-> (actuator.mode != apbc_pkg::MODE_CODE_RESERVED))
        else $error("reserved mode code reported");

endmodule
